FILE: rtl/core/aat_pkg.sv
// Shared types, constants and helpers for the box affine transform.
// Holds the payload structs, register indexes and the saturating round.
// No dependencies; imported by aat_axis and aabb_affine_transform.
package aat_pkg;

    localparam int COORD_W  = 32;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int FRAC_BITS = 16;
    localparam int REG_W    = 64;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [SUM_W-FRAC_BITS-1:0] rnd_t;

    localparam sum_t  HALF_LSB  = sum_t'(1) <<< (FRAC_BITS - 1);
    localparam rnd_t  COORD_MAX = rnd_t'(32'sh7FFF_FFFF);
    localparam rnd_t  COORD_MIN = rnd_t'(32'sh8000_0000);

    // Register reset values form the identity transform
    localparam logic [REG_W-1:0] ROW_X_LIN_RST = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] ROW_X_ZT_RST  = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] ROW_Y_LIN_RST = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] ROW_Y_ZT_RST  = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] ROW_Z_LIN_RST = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] ROW_Z_ZT_RST  = 64'h0000_0000_0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X_LIN = 3'd0,
        CFG_ROW_X_ZT  = 3'd1,
        CFG_ROW_Y_LIN = 3'd2,
        CFG_ROW_Y_ZT  = 3'd3,
        CFG_ROW_Z_LIN = 3'd4,
        CFG_ROW_Z_ZT  = 3'd5
    } cfg_idx_e;

    typedef struct packed {
        coord_t box_lo_x;
        coord_t box_lo_y;
        coord_t box_lo_z;
        coord_t box_hi_x;
        coord_t box_hi_y;
        coord_t box_hi_z;
    } box_t;

    typedef struct packed {
        coord_t out_lo_x;
        coord_t out_lo_y;
        coord_t out_lo_z;
        coord_t out_hi_x;
        coord_t out_hi_y;
        coord_t out_hi_z;
        logic   overflowed;
        logic   input_inverted;
    } res_t;

    // Advance strobes for the datapath stages held inside each axis
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } axis_en_t;

    typedef struct packed {
        coord_t value;
        logic   ovf;
    } sat_t;

    // Exact signed Q16.16 x Q16.16 product in Q32.32
    function automatic prod_t mul_q(coord_t a, coord_t b);
        mul_q = prod_t'(a) * prod_t'(b);
    endfunction

    // Drop the low 16 fraction bits of a Q34.32 sum (half already added) and clamp to Q16.16
    function automatic sat_t round_sat(sum_t s);
        rnd_t r;
        sat_t o;
        r = s[SUM_W-1:FRAC_BITS];
        if (r > COORD_MAX)
        begin
            o.value = COORD_MAX[COORD_W-1:0];
            o.ovf   = 1'b1;
        end
        else if (r < COORD_MIN)
        begin
            o.value = COORD_MIN[COORD_W-1:0];
            o.ovf   = 1'b1;
        end
        else
        begin
            o.value = r[COORD_W-1:0];
            o.ovf   = 1'b0;
        end
        return o;
    endfunction

endpackage

FILE: rtl/core/aat_axis.sv
// One output axis of the box transform: products, per-term min/max, row sums,
// then rounding and clamp of the low and high bound. Depends on aat_pkg.
module aat_axis (
    input  logic              clk,
    input  aat_pkg::axis_en_t en,
    input  aat_pkg::coord_t   lo [3],
    input  aat_pkg::coord_t   hi [3],
    input  logic [63:0]       lin,
    input  logic [63:0]       ztr,
    output aat_pkg::coord_t   t_lo,
    output aat_pkg::coord_t   t_hi,
    output logic              ovf
);
    import aat_pkg::*;

    coord_t coef [3];
    coord_t trans;
    prod_t  prod_lo_reg [3];
    prod_t  prod_hi_reg [3];
    prod_t  mn_reg [3];
    prod_t  mx_reg [3];
    sum_t   sum_lo_reg;
    sum_t   sum_hi_reg;
    sat_t   sat_lo;
    sat_t   sat_hi;

    assign coef[0] = lin[COORD_W-1:0];
    assign coef[1] = lin[REG_W-1:COORD_W];
    assign coef[2] = ztr[COORD_W-1:0];
    assign trans   = ztr[REG_W-1:COORD_W];

    // Stage 2: each coefficient times both candidate coordinates
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_lo_reg[k] <= mul_q(coef[k], lo[k]);
                prod_hi_reg[k] <= mul_q(coef[k], hi[k]);
            end
        end
    end

    // Stage 3: pick the smaller and larger term; corners vary each term freely
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (prod_lo_reg[k] < prod_hi_reg[k])
                begin
                    mn_reg[k] <= prod_lo_reg[k];
                    mx_reg[k] <= prod_hi_reg[k];
                end
                else
                begin
                    mn_reg[k] <= prod_hi_reg[k];
                    mx_reg[k] <= prod_lo_reg[k];
                end
            end
        end
    end

    // Stage 4: add the terms, the translation and the rounding half
    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            sum_lo_reg <= sum_t'(mn_reg[0]) + sum_t'(mn_reg[1]) + sum_t'(mn_reg[2])
                        + (sum_t'(trans) <<< FRAC_BITS) + HALF_LSB;
            sum_hi_reg <= sum_t'(mx_reg[0]) + sum_t'(mx_reg[1]) + sum_t'(mx_reg[2])
                        + (sum_t'(trans) <<< FRAC_BITS) + HALF_LSB;
        end
    end

    // Round and clamp; monotonic, so bounds of the sums give bounds of the corners
    assign sat_lo = round_sat(sum_lo_reg);
    assign sat_hi = round_sat(sum_hi_reg);
    assign t_lo   = sat_lo.value;
    assign t_hi   = sat_hi.value;
    assign ovf    = sat_lo.ovf | sat_hi.ovf;

endmodule

FILE: rtl/core/aabb_affine_transform.sv
// Top level of the box affine transform: input stage, configuration registers,
// three axis datapaths and the output register. Depends on aat_pkg and aat_axis.
//
// Maps an axis-aligned box (signed Q16.16 min and max corners) through the affine
// part of a 4x4 matrix held in six 64-bit registers and returns the bounding box
// of the eight transformed corners, rounded half up and clamped to Q16.16, with
// flags for clamping and for an input whose min exceeds its max. The block takes
// one box per cycle while the output is not stalled; it has a five-stage pipeline
// (input register, 18 parallel 32x32 multipliers, term min/max, row sums,
// round/clamp output register), each stage holding independently so bubbles
// close up under output stall. The user must write the registers only while no
// box is in flight; the block does not enforce this. Reset loads the identity transform.
module aabb_affine_transform (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aat_pkg::REG_W-1:0]       cfg_data,
    input  logic                            box_valid,
    output logic                            box_stall,
    input  aat_pkg::box_t                   box,
    output logic                            res_valid,
    input  logic                            res_stall,
    output aat_pkg::res_t                   res
);
    import aat_pkg::*;

    logic [REG_W-1:0] row_reg [6];
    box_t     box_reg;
    logic     v1_reg, v2_reg, v3_reg, v4_reg, res_valid_reg;
    logic     inv2_reg, inv3_reg, inv4_reg;
    res_t     res_reg;
    res_t     res_next;
    axis_en_t en;
    logic     en1, en5;
    coord_t   lo [3];
    coord_t   hi [3];
    coord_t   t_lo [3];
    coord_t   t_hi [3];
    logic     ovf [3];
    logic     inv;

    // Configuration writes; indexes past the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[CFG_ROW_X_LIN] <= ROW_X_LIN_RST;
            row_reg[CFG_ROW_X_ZT]  <= ROW_X_ZT_RST;
            row_reg[CFG_ROW_Y_LIN] <= ROW_Y_LIN_RST;
            row_reg[CFG_ROW_Y_ZT]  <= ROW_Y_ZT_RST;
            row_reg[CFG_ROW_Z_LIN] <= ROW_Z_LIN_RST;
            row_reg[CFG_ROW_Z_ZT]  <= ROW_Z_ZT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_X_LIN: row_reg[CFG_ROW_X_LIN] <= cfg_data;
                CFG_ROW_X_ZT:  row_reg[CFG_ROW_X_ZT]  <= cfg_data;
                CFG_ROW_Y_LIN: row_reg[CFG_ROW_Y_LIN] <= cfg_data;
                CFG_ROW_Y_ZT:  row_reg[CFG_ROW_Y_ZT]  <= cfg_data;
                CFG_ROW_Z_LIN: row_reg[CFG_ROW_Z_LIN] <= cfg_data;
                CFG_ROW_Z_ZT:  row_reg[CFG_ROW_Z_ZT]  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance each stage when it is empty or its successor advances
    assign en5       = !res_valid_reg || !res_stall;
    assign en.s4     = !v4_reg || en5;
    assign en.s3     = !v3_reg || en.s4;
    assign en.s2     = !v2_reg || en.s3;
    assign en1       = !v1_reg || en.s2;
    assign box_stall = !en1;

    // Valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= box_valid;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en.s3)
                v3_reg <= v2_reg;
            if (en.s4)
                v4_reg <= v3_reg;
            if (en5)
                res_valid_reg <= v4_reg;
        end
    end

    // Stage 1: capture the box on transfer
    always_ff @(posedge clk)
    begin
        if (en1)
            box_reg <= box;
    end

    assign lo[0] = box_reg.box_lo_x;
    assign lo[1] = box_reg.box_lo_y;
    assign lo[2] = box_reg.box_lo_z;
    assign hi[0] = box_reg.box_hi_x;
    assign hi[1] = box_reg.box_hi_y;
    assign hi[2] = box_reg.box_hi_z;
    assign inv   = (lo[0] > hi[0]) || (lo[1] > hi[1]) || (lo[2] > hi[2]);

    // Carry the inverted-box flag down to the output stage
    always_ff @(posedge clk)
    begin
        if (en.s2)
            inv2_reg <= inv;
        if (en.s3)
            inv3_reg <= inv2_reg;
        if (en.s4)
            inv4_reg <= inv3_reg;
    end

    // One datapath per output axis
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        aat_axis u_axis (
            .clk  (clk),
            .en   (en),
            .lo   (lo),
            .hi   (hi),
            .lin  (row_reg[2 * a]),
            .ztr  (row_reg[2 * a + 1]),
            .t_lo (t_lo[a]),
            .t_hi (t_hi[a]),
            .ovf  (ovf[a])
        );
    end

    // Stage 5: assemble and hold the result until its transfer out
    always_comb
    begin
        res_next.out_lo_x       = t_lo[0];
        res_next.out_lo_y       = t_lo[1];
        res_next.out_lo_z       = t_lo[2];
        res_next.out_hi_x       = t_hi[0];
        res_next.out_hi_y       = t_hi[1];
        res_next.out_hi_z       = t_hi[2];
        res_next.overflowed     = ovf[0] | ovf[1] | ovf[2];
        res_next.input_inverted = inv4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The input side only stalls when the first stage is full and blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        box_stall |-> v1_reg)
        else $error("input stalled with empty first stage");

    // A transferred box occupies the first stage next cycle
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_stall |=> v1_reg)
        else $error("transferred box lost");

    // Transformed bounds are ordered on every axis
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.out_lo_x <= res.out_hi_x) && (res.out_lo_y <= res.out_hi_y)
                      && (res.out_lo_z <= res.out_hi_z))
        else $error("output box min above max");

    // A clamp leaves some bound at the edge of the range
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.overflowed |->
            (res.out_hi_x == 32'sh7FFF_FFFF) || (res.out_hi_y == 32'sh7FFF_FFFF)
            || (res.out_hi_z == 32'sh7FFF_FFFF) || (res.out_lo_x == 32'sh8000_0000)
            || (res.out_lo_y == 32'sh8000_0000) || (res.out_lo_z == 32'sh8000_0000))
        else $error("overflow flag without clamped bound");

endmodule
